[rtl/lphd_pkg.sv]
package lphd_pkg;

    localparam int ADC_BITS   = 10;
    localparam int ELAPSED_W  = 16;
    localparam int SETPOINT_W = 8;
    localparam int GAIN_P_W   = 12;
    localparam int GAIN_I_W   = 12;
    localparam int GAIN_D_W   = 16;
    localparam int DUTY_W     = 8;
    localparam int TEMP_W     = 7;
    localparam int ERR_W      = 10;
    localparam int INT_W      = 16;

    localparam int IDATA_W    = 32;
    localparam int ODATA_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // shared serial multiply / divide unit
    localparam int MAG_W   = 9;
    localparam int DVS_W   = 16;
    localparam int DVD_W   = 28;
    localparam int PROD_W  = DVS_W + MAG_W;
    localparam int CNT_W   = 5;
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MAG_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DVD_W);

    localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 8'd0;
    localparam logic [GAIN_P_W-1:0]   GAIN_P_RST   = 12'd50;
    localparam logic [GAIN_I_W-1:0]   GAIN_I_RST   = 12'd30;
    localparam logic [GAIN_D_W-1:0]   GAIN_D_RST   = 16'd1200;

    localparam logic [DVS_W-1:0]  HUNDRED    = 16'd100;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT = 8'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D
    } t_cfg_idx;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic             start;
        t_mdu_op          op;
        logic [DVD_W-1:0] opa;
        logic [DVS_W-1:0] opb;
    } t_mdu_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] result;
    } t_mdu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_PDIV,
        S_IMUL,
        S_INUM,
        S_IDIV,
        S_DMUL,
        S_DDIV,
        S_SUM
    } t_state;

endpackage

[rtl/lphd_mdu.sv]
module lphd_mdu import lphd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mdu_req i_req,
    output t_mdu_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    t_mdu_op          r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W:0]   r_rem, n_rem;
    logic [DVS_W-1:0] r_opb, n_opb;

    logic [DVS_W:0]   w_sum;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_sub;
    logic             w_ge;

    // mul: r_opb multiplicand, r_quo low bits multiplier, r_rem high product half
    // div: r_quo dividend/quotient, r_rem partial remainder, r_opb divisor
    always_comb begin
        w_sum   = r_rem + (r_quo[0] ? {1'b0, r_opb} : '0);
        w_shift = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        w_sub   = w_shift - {1'b0, r_opb};
        w_ge    = (w_shift >= {1'b0, r_opb});

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_opb  = r_opb;

        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = (i_req.op == MDU_MUL) ? MUL_STEPS : DIV_STEPS;
            n_quo  = i_req.opa;
            n_rem  = '0;
            n_opb  = i_req.opb;
        end else if (r_busy) begin
            if (r_op == MDU_MUL) begin
                n_rem             = {1'b0, w_sum[DVS_W:1]};
                n_quo[MAG_W-1:0]  = {w_sum[0], r_quo[MAG_W-1:1]};
            end else begin
                n_rem = w_ge ? w_sub : w_shift;
                n_quo = {r_quo[DVD_W-2:0], w_ge};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= MDU_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_opb <= n_opb;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == MDU_MUL)
                        ? {{(DVD_W-PROD_W){1'b0}}, r_rem[DVS_W-1:0], r_quo[MAG_W-1:0]}
                        : r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("start while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("done without a finished operation");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("busy with empty step count");

endmodule

[rtl/leaky_pid_heater_duty.sv]
// PID heater duty controller with a leaky integral.
//
// Input stream: one transaction per sample, tdata carries the converter
// sample and the milliseconds since the previous sample. Output stream: one
// transaction per input with the heater duty and the scaled temperature.
// The user must write gains and the setpoint through the register port only
// while the block is idle (unchecked); a write takes effect on the next clock.
//
// A new input is taken only in the idle state, once the previous item has
// been written to the output register. The processing time is set by the
// single bit-serial multiply/divide unit: two or three multiplies of 9
// steps and up to three divides of 28 steps, one bit per cycle, plus setup
// cycles; the derivative pair runs only for nonzero elapsed_ms.
//
// Reset restores the register defaults and clears the integral and the
// previous error. The result sits in an output register; if the receiver
// stalls, the next item is still accepted and processed, and only its
// final write waits until the held result is taken.
module leaky_pid_heater_duty import lphd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IDATA_W-1:0]    s_axis_tdata,   // adc_sample[9:0], elapsed_ms[25:10]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [ODATA_W-1:0]    m_axis_tdata,   // duty[7:0], temperature[14:8]
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state r_state, n_state;
    logic   r_go;

    logic [SETPOINT_W-1:0] r_setpoint;
    logic [GAIN_P_W-1:0]   r_gain_p;
    logic [GAIN_I_W-1:0]   r_gain_i;
    logic [GAIN_D_W-1:0]   r_gain_d;

    logic [INT_W-1:0]      r_integral;
    logic [ERR_W-1:0]      r_last_err;

    logic [TEMP_W-1:0]     r_temp;
    logic [ERR_W-1:0]      r_err;
    logic [ERR_W-1:0]      r_diff;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [INT_W-1:0]      r_p;
    logic [DVD_W:0]        r_num;
    logic [DVD_W-1:0]      r_dmag;

    logic                  r_out_valid;
    logic [DUTY_W-1:0]     r_out_duty;
    logic [TEMP_W-1:0]     r_out_temp;

    t_mdu_req              w_req;
    t_mdu_rsp              w_rsp;

    logic                  w_accept;
    logic                  w_load;
    logic [ADC_BITS-1:0]   w_sample;
    logic [ADC_BITS+6:0]   w_scaled;
    logic [TEMP_W-1:0]     w_temp;
    logic [ERR_W-1:0]      w_err;
    logic [ERR_W-1:0]      w_err_mag;
    logic [ERR_W-1:0]      w_diff_mag;
    logic [INT_W-1:0]      w_q16;
    logic [22:0]           w_iprod;
    logic [DVD_W:0]        w_m100;
    logic [DVD_W:0]        w_int_ext;
    logic [DVD_W:0]        w_num_mag;
    logic [DVD_W-1:0]      w_d10;
    logic [DVD_W+1:0]      w_d_ext;
    logic [DVD_W+1:0]      w_d_sgn;
    logic [DVD_W+1:0]      w_sum;
    logic [DUTY_W-1:0]     w_duty;

    lphd_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = (r_state == S_SUM) && (!r_out_valid || m_axis_tready);

    // temperature = sample * 100 >> ADC_BITS
    always_comb begin
        w_sample = s_axis_tdata[ADC_BITS-1:0];
        w_scaled = {1'b0, w_sample, 6'b0}
                 + {2'b0, w_sample, 5'b0}
                 + {5'b0, w_sample, 2'b0};
        w_temp   = w_scaled[ADC_BITS+6:ADC_BITS];
        w_err    = {2'b00, r_setpoint} - {3'b000, w_temp} + ERR_W'(1);
    end

    always_comb begin
        w_err_mag  = r_err[ERR_W-1] ? (~r_err + ERR_W'(1)) : r_err;
        w_diff_mag = r_diff[ERR_W-1] ? (~r_diff + ERR_W'(1)) : r_diff;
        w_q16      = w_rsp.result[INT_W-1:0];
        w_iprod    = w_rsp.result[22:0];
        w_m100     = {w_iprod, 6'b0} + {1'b0, w_iprod, 5'b0} + {4'b0, w_iprod, 2'b0};
        w_int_ext  = {{(DVD_W+1-INT_W){r_integral[INT_W-1]}}, r_integral};
        w_num_mag  = r_num[DVD_W] ? (~r_num + (DVD_W+1)'(1)) : r_num;
        w_d10      = {w_rsp.result[DVD_W-4:0], 3'b0} + {1'b0, w_rsp.result[DVD_W-3:0], 1'b0};
        w_d_ext    = {2'b00, r_dmag};
        w_d_sgn    = r_diff[ERR_W-1] ? (~w_d_ext + (DVD_W+2)'(1)) : w_d_ext;
        w_sum      = {{(DVD_W+2-INT_W){r_p[INT_W-1]}}, r_p}
                   + {{(DVD_W+2-INT_W){r_integral[INT_W-1]}}, r_integral}
                   + w_d_sgn;
        if (w_sum[DVD_W+1]) begin
            w_duty = '0;
        end else if (|w_sum[DVD_W:DUTY_W]) begin
            w_duty = DUTY_LIMIT;
        end else begin
            w_duty = w_sum[DUTY_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_PMUL;
            S_PMUL: if (w_rsp.done) n_state = S_PDIV;
            S_PDIV: if (w_rsp.done) n_state = S_IMUL;
            S_IMUL: if (w_rsp.done) n_state = S_INUM;
            S_INUM: n_state = S_IDIV;
            S_IDIV: begin
                if (w_rsp.done) begin
                    n_state = (r_elapsed == '0) ? S_SUM : S_DMUL;
                end
            end
            S_DMUL: if (w_rsp.done) n_state = S_DDIV;
            S_DDIV: if (w_rsp.done) n_state = S_SUM;
            S_SUM:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_req.start   = 1'b0;
        w_req.op      = MDU_MUL;
        w_req.opa     = '0;
        w_req.opb     = '0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_PMUL: begin
                w_req.start = r_go;
                w_req.opa   = {{(DVD_W-MAG_W){1'b0}}, w_err_mag[MAG_W-1:0]};
                w_req.opb   = {{(DVS_W-GAIN_P_W){1'b0}}, r_gain_p};
            end
            S_PDIV: begin
                w_req.start = r_go;
                w_req.op    = MDU_DIV;
                w_req.opa   = w_rsp.result;
                w_req.opb   = HUNDRED;
            end
            S_IMUL: begin
                w_req.start = r_go;
                w_req.opa   = {{(DVD_W-MAG_W){1'b0}}, w_err_mag[MAG_W-1:0]};
                w_req.opb   = {{(DVS_W-GAIN_I_W){1'b0}}, r_gain_i};
            end
            S_IDIV: begin
                w_req.start = r_go;
                w_req.op    = MDU_DIV;
                w_req.opa   = w_num_mag[DVD_W-1:0];
                w_req.opb   = HUNDRED;
            end
            S_DMUL: begin
                w_req.start = r_go;
                w_req.opa   = {{(DVD_W-MAG_W){1'b0}}, w_diff_mag[MAG_W-1:0]};
                w_req.opb   = r_gain_d;
            end
            S_DDIV: begin
                w_req.start = r_go;
                w_req.op    = MDU_DIV;
                w_req.opa   = w_d10;
                w_req.opb   = r_elapsed;
            end
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SETPOINT_RST;
            r_gain_p   <= GAIN_P_RST;
            r_gain_i   <= GAIN_I_RST;
            r_gain_d   <= GAIN_D_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SETPOINT: r_setpoint <= i_cfg_wdata[SETPOINT_W-1:0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_wdata[GAIN_P_W-1:0];
                CFG_GAIN_I:   r_gain_i   <= i_cfg_wdata[GAIN_I_W-1:0];
                CFG_GAIN_D:   r_gain_d   <= i_cfg_wdata[GAIN_D_W-1:0];
                default:      r_setpoint <= r_setpoint;
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else begin
            if (w_accept) begin
                r_last_err <= w_err;
            end
            if (r_state == S_IDIV && w_rsp.done) begin
                if (r_num[DVD_W]) begin
                    r_integral <= (w_rsp.result > DVD_W'(32768)) ? 16'h8000
                                                                  : (~w_q16 + 16'd1);
                end else begin
                    r_integral <= (w_rsp.result > DVD_W'(32767)) ? 16'h7fff : w_q16;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_temp    <= w_temp;
            r_err     <= w_err;
            r_diff    <= w_err - r_last_err;
            r_elapsed <= s_axis_tdata[ADC_BITS+ELAPSED_W-1:ADC_BITS];
        end
        if (r_state == S_PDIV && w_rsp.done) begin
            r_p <= r_err[ERR_W-1] ? (~w_q16 + 16'd1) : w_q16;
        end
        if (r_state == S_INUM) begin
            r_num <= r_err[ERR_W-1] ? (w_int_ext - w_m100) : (w_int_ext + w_m100);
        end
        if (r_state == S_IDIV && w_rsp.done) begin
            r_dmag <= '0;
        end
        if (r_state == S_DDIV && w_rsp.done) begin
            r_dmag <= w_rsp.result;
        end
        if (w_load) begin
            r_out_duty <= w_duty;
            r_out_temp <= r_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ODATA_W-DUTY_W-TEMP_W){1'b0}}, r_out_temp, r_out_duty};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PMUL && r_go))
        else $error("accepted item did not start the multiply");

    a_no_deriv_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DMUL || r_state == S_DDIV) |-> (r_elapsed != '0))
        else $error("derivative path entered with zero elapsed time");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented after sum");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !s_axis_tready)
        else $error("input ready while an operation starts");

endmodule

[bench/tb_leaky_pid_heater_duty.sv]
module tb_leaky_pid_heater_duty import lphd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES = 8;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] temperature;
    } t_heater_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IDATA_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [ODATA_W-1:0]    m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // controller copy: registers and loop state
    logic [SETPOINT_W-1:0] cur_setpoint;
    logic [GAIN_P_W-1:0]   cur_gain_p;
    logic [GAIN_I_W-1:0]   cur_gain_i;
    logic [GAIN_D_W-1:0]   cur_gain_d;
    longint                integ_acc;
    longint                prev_error;

    t_heater_result pending_results[$];
    t_heater_result want;
    int             mismatch_count = 0;
    int             stuck_cycles = 0;

    bit tx_idle_en = 1'b1;
    bit rx_stall_en = 1'b1;
    int tx_burst_left = 0;
    int rx_stall_left = 0;

    leaky_pid_heater_duty dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one control update: returns duty and temperature, advances the loop state
    function automatic t_heater_result pid_update(logic [ADC_BITS-1:0] adc,
                                                  logic [ELAPSED_W-1:0] ms_in);
        longint temp_c, err, sp, kp, ki, kd, ms, p_term, i_term, d_term, total;
        t_heater_result r;
        sp = cur_setpoint;
        kp = cur_gain_p;
        ki = cur_gain_i;
        kd = cur_gain_d;
        ms = ms_in;
        temp_c = adc;
        temp_c = (temp_c * 100) >> ADC_BITS;
        err = sp - temp_c + 1;
        p_term = (kp * err) / 100;
        i_term = (integ_acc + 100 * ki * err) / 100;
        if (i_term > 32767)
            i_term = 32767;
        else if (i_term < -32768)
            i_term = -32768;
        d_term = (ms == 0) ? 0 : (10 * kd * (err - prev_error)) / ms;
        total = p_term + i_term + d_term;
        if (total < 0)
            r.duty = '0;
        else if (total > 255)
            r.duty = DUTY_LIMIT;
        else
            r.duty = DUTY_W'(total);
        r.temperature = TEMP_W'(temp_c);
        integ_acc = i_term;
        prev_error = err;
        return r;
    endfunction

    task automatic apply_reset();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        cur_setpoint = SETPOINT_RST;
        cur_gain_p = GAIN_P_RST;
        cur_gain_i = GAIN_I_RST;
        cur_gain_d = GAIN_D_RST;
        integ_acc = 0;
        prev_error = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        case (idx)
            CFG_SETPOINT: cur_setpoint = value[SETPOINT_W-1:0];
            CFG_GAIN_P:   cur_gain_p = value[GAIN_P_W-1:0];
            CFG_GAIN_I:   cur_gain_i = value[GAIN_I_W-1:0];
            CFG_GAIN_D:   cur_gain_d = value[GAIN_D_W-1:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] sp, logic [CFG_DATA_W-1:0] kp,
                             logic [CFG_DATA_W-1:0] ki, logic [CFG_DATA_W-1:0] kd);
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
    endtask

    task automatic send_sample(logic [ADC_BITS-1:0] adc, logic [ELAPSED_W-1:0] ms);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en) begin
            if (tx_burst_left == 0) begin
                s_axis_tvalid = 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 140)
                                                  : $urandom_range(1, 8);
                repeat (gap) @(negedge i_clk);
                tx_burst_left = $urandom_range(1, 12);
            end
            tx_burst_left--;
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'b0, ms, adc};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_results.push_back(pid_update(adc, ms));
    endtask

    // also the pause before any register write
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_sample(10'd0, 16'd0);
        send_sample(10'd1023, 16'd65535);
        send_sample(10'd512, 16'd1);
        send_sample(10'd0, 16'd1);
        send_sample(10'd1023, 16'd0);
    endtask

    task automatic test_directed_cases();
        // drive hard positive: duty above 255 and integral up to its ceiling
        wait_for_results();
        write_all(16'h00FF, 16'h0FFF, 16'h0FFF, 16'hFFFF);
        repeat (4) send_sample(10'd0, 16'd1);
        // hot input with zero target: negative sum and integral floor
        wait_for_results();
        write_reg(CFG_SETPOINT, 16'hFF00);
        repeat (4) send_sample(10'd1023, 16'd65535);
        // large derivative swings, zero elapsed time disables the term
        wait_for_results();
        write_all(16'd50, 16'd0, 16'd0, 16'hFFFF);
        send_sample(10'd0, 16'd1);
        send_sample(10'd1023, 16'd1);
        send_sample(10'd0, 16'd0);
        send_sample(10'd1023, 16'd0);
        send_sample(10'd0, 16'd65535);
        // duty inside range; upper write data bits are dropped
        wait_for_results();
        write_all(16'hFF37, 16'hF064, 16'hF001, 16'd3);
        send_sample(10'd563, 16'd10);
        send_sample(10'd570, 16'd20);
        send_sample(10'd550, 16'd0);
        send_sample(10'd600, 16'd5);
        send_sample(10'd1, 16'd100);
    endtask

    task automatic send_random_item();
        int sel;
        int base;
        logic [ADC_BITS-1:0] adc;
        logic [ELAPSED_W-1:0] ms;
        sel = $urandom_range(0, 7);
        if (sel < 4) begin
            adc = ADC_BITS'($urandom_range(0, 1023));
        end else if (sel < 7) begin
            base = int'(cur_setpoint) * 1024 / 100 + int'($urandom_range(0, 80)) - 40;
            if (base < 0)
                base = 0;
            if (base > 1023)
                base = 1023;
            adc = base[ADC_BITS-1:0];
        end else begin
            adc = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        end
        sel = $urandom_range(0, 7);
        case (sel)
            0:       ms = '0;
            1:       ms = 16'hFFFF;
            2, 3:    ms = ELAPSED_W'($urandom_range(1, 20));
            default: ms = ELAPSED_W'($urandom_range(0, 65535));
        endcase
        send_sample(adc, ms);
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] sp;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_for_results();
            sp = {8'($urandom), 8'($urandom_range(0, 110))};
            if (ph == 0)
                write_all(16'd0, 16'd0, 16'd0, 16'd0);
            else if (ph == 1)
                write_all(16'hFFFF, 16'h0FFF, 16'h0FFF, 16'hFFFF);
            else if (ph % 2 == 0)
                write_all(sp, CFG_DATA_W'($urandom_range(0, 400)),
                          CFG_DATA_W'($urandom_range(0, 4)),
                          CFG_DATA_W'($urandom_range(0, 300)));
            else
                write_all({8'($urandom), 8'($urandom)},
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 4095)),
                          CFG_DATA_W'($urandom_range(0, 65535)));
            tx_idle_en = (ph % 4 != 3);
            rx_stall_en = (ph % 4 != 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_random_item();
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stall_left > 0) begin
                m_axis_tready = 1'b0;
                rx_stall_left--;
            end else if (rx_stall_en && $urandom_range(0, 39) == 0) begin
                m_axis_tready = 1'b0;
                rx_stall_left = $urandom_range(1, 150);
            end else begin
                m_axis_tready = rx_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.duty) begin
                    mismatch_count++;
                    $display("%0t: duty expected %0d actual %0d",
                             $time, want.duty, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[14:8] !== want.temperature) begin
                    mismatch_count++;
                    $display("%0t: temperature expected %0d actual %0d",
                             $time, want.temperature, m_axis_tdata[14:8]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        apply_reset();
        test_reset_defaults();
        test_directed_cases();
        test_random_phases();
        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
